// ===== rtl/spq_pkg.sv =====
// Shared types and constants for the sorted priority queue.
`timescale 1ns / 1ps

package spq_pkg;

  localparam int DefCapacity   = 16;
  localparam int DefPrioBits   = 8;
  localparam int ValueW        = 32;
  localparam int InPrioW       = 8;
  localparam int StatusW       = 2;
  localparam int OccW          = 5;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  localparam logic [StatusW-1:0] ST_OK    = 2'd0;
  localparam logic [StatusW-1:0] ST_UNDER = 2'd1;
  localparam logic [StatusW-1:0] ST_OVER  = 2'd2;

  typedef struct packed {
    logic                     command;
    logic signed [ValueW-1:0] item_value;
    logic [InPrioW-1:0]       item_priority;
  } in_t;

  typedef struct packed {
    logic [StatusW-1:0]       status;
    logic                     out_valid;
    logic signed [ValueW-1:0] out_value;
    logic [InPrioW-1:0]       out_priority;
    logic [OccW-1:0]          occupancy;
  } out_t;

  // Per-cycle command broadcast to every cell of the row.
  typedef struct packed {
    logic ins;
    logic rem;
  } ctrl_t;

endpackage

// ===== rtl/sorted_priority_queue.sv =====
// Top level of the sorted priority queue: row of cells, count and result register.
`timescale 1ns / 1ps
//
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_data_i) carries a command:
//   insert a (value, priority) pair, or remove the front pair. Every
//   accepted command yields exactly one result transfer on the output
//   channel (out_valid_o / out_ready_i / out_data_o) holding status,
//   the removed pair (on a good remove) and the occupancy after the step.
//   Pairs are kept in ascending priority order; equal priorities leave in
//   arrival order. Remove on empty reports underflow, insert on full is
//   dropped and reports overflow.
//   Latency: the result appears the cycle after the input transfer.
//   Throughput: one command per cycle unless a held result stalls input;
//   every cell of the row updates together, so the cell update sets the rate.
//   Stall: a held result blocks new input only while out_ready_i is low;
//   input is taken in the same cycle the pending result is taken.
//   Reset: the queue comes up empty with no result pending.
//
module sorted_priority_queue #(
  parameter int CAPACITY      = spq_pkg::DefCapacity,
  parameter int PRIORITY_BITS = spq_pkg::DefPrioBits
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  spq_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output spq_pkg::out_t out_data_o
);
  import spq_pkg::*;

  localparam int CntW  = $clog2(CAPACITY + 1);
  localparam int KeepW = (PRIORITY_BITS < InPrioW) ? PRIORITY_BITS : InPrioW;
  localparam int OccKW = (CntW < OccW) ? CntW : OccW;

  logic [CntW-1:0] count_q, count_d;
  logic            out_valid_q;
  out_t            out_q, out_d;

  logic                     accept, is_ins, full, empty;
  ctrl_t                    ctrl;
  logic [PRIORITY_BITS-1:0] new_prio;

  logic                     stay  [CAPACITY];
  logic signed [ValueW-1:0] value [CAPACITY];
  logic [PRIORITY_BITS-1:0] prio  [CAPACITY];

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_ins     = (in_data_i.command == CMD_INSERT);
  assign full       = (count_q == CntW'(CAPACITY));
  assign empty      = (count_q == '0);
  assign ctrl.ins   = accept && is_ins && !full;
  assign ctrl.rem   = accept && !is_ins && !empty;

  always_comb begin
    new_prio = '0;
    new_prio[KeepW-1:0] = in_data_i.item_priority[KeepW-1:0];
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                     l_stay;
    logic signed [ValueW-1:0] l_value, r_value;
    logic [PRIORITY_BITS-1:0] l_prio, r_prio;

    if (i == 0) begin : g_head
      assign l_stay  = 1'b1;
      assign l_value = in_data_i.item_value;
      assign l_prio  = new_prio;
    end else begin : g_mid
      assign l_stay  = stay[i-1];
      assign l_value = value[i-1];
      assign l_prio  = prio[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign r_value = '0;
      assign r_prio  = '0;
    end else begin : g_body
      assign r_value = value[i+1];
      assign r_prio  = prio[i+1];
    end

    spq_cell #(
      .PRIORITY_BITS(PRIORITY_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .occ_i        (count_q > CntW'(i)),
      .new_value_i  (in_data_i.item_value),
      .new_prio_i   (new_prio),
      .left_stay_i  (l_stay),
      .left_value_i (l_value),
      .left_prio_i  (l_prio),
      .right_value_i(r_value),
      .right_prio_i (r_prio),
      .stay_o       (stay[i]),
      .value_o      (value[i]),
      .prio_o       (prio[i])
    );
  end

  always_comb begin
    count_d = count_q;
    if (ctrl.ins) begin
      count_d = count_q + CntW'(1);
    end else if (ctrl.rem) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_comb begin
    out_d = '0;
    out_d.occupancy[OccKW-1:0] = count_d[OccKW-1:0];
    if (is_ins) begin
      out_d.status = full ? ST_OVER : ST_OK;
    end else if (empty) begin
      out_d.status = ST_UNDER;
    end else begin
      out_d.status    = ST_OK;
      out_d.out_valid = 1'b1;
      out_d.out_value = value[0];
      out_d.out_priority[KeepW-1:0] = prio[0][KeepW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("held count above capacity");

  a_result_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_o)
    else $error("no result after input transfer");

  a_full_drop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_ins && full) |=> (count_q == CntW'(CAPACITY)))
    else $error("overflow insert changed the queue");

  a_remove_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.rem |=> (count_q == $past(count_q) - CntW'(1)))
    else $error("remove did not drop one pair");

  a_head_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q >= CntW'(2)) |-> (prio[0] <= prio[1]))
    else $error("front pair out of order");

endmodule

// ===== rtl/spq_cell.sv =====
// One slot of the sorted row: holds a pair and shifts left or right.
`timescale 1ns / 1ps

module spq_cell #(
  parameter int PRIORITY_BITS = spq_pkg::DefPrioBits
) (
  input  logic                              clk_i,
  input  spq_pkg::ctrl_t                    ctrl_i,
  input  logic                              occ_i,
  input  logic signed [spq_pkg::ValueW-1:0] new_value_i,
  input  logic [PRIORITY_BITS-1:0]          new_prio_i,
  input  logic                              left_stay_i,
  input  logic signed [spq_pkg::ValueW-1:0] left_value_i,
  input  logic [PRIORITY_BITS-1:0]          left_prio_i,
  input  logic signed [spq_pkg::ValueW-1:0] right_value_i,
  input  logic [PRIORITY_BITS-1:0]          right_prio_i,
  output logic                              stay_o,
  output logic signed [spq_pkg::ValueW-1:0] value_o,
  output logic [PRIORITY_BITS-1:0]          prio_o
);
  import spq_pkg::*;

  logic signed [ValueW-1:0] value_q, value_d;
  logic [PRIORITY_BITS-1:0] prio_q, prio_d;

  // Held pairs with priority <= new one stay put; they form a prefix.
  assign stay_o = occ_i && (prio_q <= new_prio_i);

  always_comb begin
    value_d = value_q;
    prio_d  = prio_q;
    if (ctrl_i.ins) begin
      if (!stay_o) begin
        if (left_stay_i) begin
          value_d = new_value_i;
          prio_d  = new_prio_i;
        end else begin
          value_d = left_value_i;
          prio_d  = left_prio_i;
        end
      end
    end else if (ctrl_i.rem) begin
      value_d = right_value_i;
      prio_d  = right_prio_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    prio_q  <= prio_d;
  end

  assign value_o = value_q;
  assign prio_o  = prio_q;

endmodule

// ===== verif/spq_checker.sv =====
// Scoreboard for the sorted priority queue: tracks the held pairs and checks every result.
`timescale 1ns / 1ps

module spq_checker #(
  parameter int CAPACITY      = spq_pkg::DefCapacity,
  parameter int PRIORITY_BITS = spq_pkg::DefPrioBits
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_ready_i,
  input  spq_pkg::in_t  in_data_i,
  input  logic          out_valid_i,
  input  logic          out_ready_i,
  input  spq_pkg::out_t out_data_i,
  output int            err_count_o,
  output int            pending_o,
  output int            overflows_o,
  output int            underflows_o
);
  import spq_pkg::*;

  localparam logic [InPrioW-1:0] PrioMask = InPrioW'((64'd1 << PRIORITY_BITS) - 64'd1);

  logic signed [ValueW-1:0] held_value [CAPACITY];
  logic [InPrioW-1:0]       held_prio  [CAPACITY];
  int                       held_n;
  out_t                     result_q [$];

  // Applies one command to the shadow queue and returns the result it must produce.
  function automatic out_t queue_step(in_t cmd);
    out_t               r;
    logic [InPrioW-1:0] pri;
    int                 pos;
    r   = '0;
    pri = cmd.item_priority & PrioMask;
    if (cmd.command == CMD_INSERT) begin
      if (held_n >= CAPACITY) begin
        r.status = ST_OVER;
      end else begin
        // new pair goes behind every pair of equal or lower priority number
        pos = 0;
        while (pos < held_n && held_prio[pos] <= pri) pos++;
        for (int i = held_n; i > pos; i--) begin
          held_value[i] = held_value[i-1];
          held_prio[i]  = held_prio[i-1];
        end
        held_value[pos] = cmd.item_value;
        held_prio[pos]  = pri;
        held_n++;
        r.status = ST_OK;
      end
    end else if (held_n == 0) begin
      r.status = ST_UNDER;
    end else begin
      r.status       = ST_OK;
      r.out_valid    = 1'b1;
      r.out_value    = held_value[0];
      r.out_priority = held_prio[0];
      for (int i = 1; i < held_n; i++) begin
        held_value[i-1] = held_value[i];
        held_prio[i-1]  = held_prio[i];
      end
      held_n--;
    end
    r.occupancy = OccW'(held_n);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] exp_v, logic [63:0] got_v);
    $display("%0t: result mismatch, %s: expected %0h, got %0h", $time, what, exp_v, got_v);
    err_count_o++;
  endtask

  task automatic compare_result(out_t exp_r, out_t got_r);
    if (got_r.status !== exp_r.status)
      report_mismatch("status", 64'(exp_r.status), 64'(got_r.status));
    if (got_r.out_valid !== exp_r.out_valid)
      report_mismatch("out_valid", 64'(exp_r.out_valid), 64'(got_r.out_valid));
    if (got_r.out_value !== exp_r.out_value)
      report_mismatch("out_value", 64'(unsigned'(exp_r.out_value)),
                      64'(unsigned'(got_r.out_value)));
    if (got_r.out_priority !== exp_r.out_priority)
      report_mismatch("out_priority", 64'(exp_r.out_priority), 64'(got_r.out_priority));
    if (got_r.occupancy !== exp_r.occupancy)
      report_mismatch("occupancy", 64'(exp_r.occupancy), 64'(got_r.occupancy));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_t r;
    if (!rst_ni) begin
      held_n = 0;
      result_q.delete();
      err_count_o  = 0;
      overflows_o  = 0;
      underflows_o = 0;
      pending_o    = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (result_q.size() == 0) begin
          report_mismatch("transfer with nothing expected", 64'd0, 64'(out_data_i));
        end else begin
          compare_result(result_q.pop_front(), out_data_i);
        end
      end
      if (in_valid_i && in_ready_i) begin
        r = queue_step(in_data_i);
        if (r.status == ST_OVER) overflows_o++;
        if (r.status == ST_UNDER) underflows_o++;
        result_q.push_back(r);
      end
      pending_o = result_q.size();
    end
  end

endmodule

// ===== verif/sorted_priority_queue_tb.sv =====
// Testbench top for the sorted priority queue: clock, reset, command traffic and verdict.
`timescale 1ns / 1ps

module sorted_priority_queue_tb;
  import spq_pkg::*;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  in_t  in_data   = '0;
  logic out_ready = 1'b0;
  logic in_ready;
  logic out_valid;
  out_t out_data;

  int err_count;
  int pending;
  int overflows;
  int underflows;

  int idle_pct  = 0;
  int stall_pct = 0;
  int n_sent    = 0;
  int n_removes = 0;

  sorted_priority_queue #(
    .CAPACITY     (DefCapacity),
    .PRIORITY_BITS(DefPrioBits)
  ) u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  spq_checker #(
    .CAPACITY     (DefCapacity),
    .PRIORITY_BITS(DefPrioBits)
  ) u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .err_count_o (err_count),
    .pending_o   (pending),
    .overflows_o (overflows),
    .underflows_o(underflows)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", pending);
    $display("end of test: mismatches");
    $finish;
  end

  function automatic in_t make_insert(logic signed [ValueW-1:0] value,
                                      logic [InPrioW-1:0] prio);
    in_t c;
    c.command       = CMD_INSERT;
    c.item_value    = value;
    c.item_priority = prio;
    return c;
  endfunction

  // payload fields are don't-care on a remove, so fill them with noise
  function automatic in_t make_remove();
    in_t c;
    c.command       = CMD_REMOVE;
    c.item_value    = $urandom;
    c.item_priority = InPrioW'($urandom_range(0, 255));
    return c;
  endfunction

  task automatic send_cmd(in_t cmd);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= cmd;
    do @(posedge clk); while (!in_ready);
    n_sent++;
    if (cmd.command == CMD_REMOVE) n_removes++;
  endtask

  task automatic pause_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin : stimulus
    int ins_pct;
    bit wide;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: underflow, extremes, equal priorities, fill to overflow
    send_cmd(make_remove());
    send_cmd(make_insert(32'sh7FFF_FFFF, 8'd255));
    send_cmd(make_insert(32'sh8000_0000, 8'd0));
    send_cmd(make_insert(32'sd0, 8'd255));
    send_cmd(make_insert(-32'sd1, 8'd128));
    send_cmd(make_insert(32'sd1, 8'd0));
    send_cmd(make_insert(32'sh5555_5555, 8'h55));
    send_cmd(make_insert(32'shAAAA_AAAA, 8'hAA));
    for (int i = 0; i < 9; i++) send_cmd(make_insert($urandom, 8'(i % 3 + 127)));
    send_cmd(make_insert(32'sd7, 8'd0));
    for (int i = 0; i < 5; i++) send_cmd(make_remove());
    pause_until_drained();

    // random: no idling, sender idle, receiver stall, both lightly
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 69; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 69; end
        default: begin idle_pct = 11; stall_pct = 11; end
      endcase
      for (int b = 0; b < 10; b++) begin
        // bias the insert/remove mix per burst so the queue sweeps empty to full
        case ($urandom_range(0, 3))
          0: ins_pct = 20;
          1: ins_pct = 50;
          2: ins_pct = 80;
          default: ins_pct = 95;
        endcase
        wide = ($urandom_range(0, 3) == 0);
        for (int k = 0; k < 50; k++) begin
          if ($urandom_range(0, 99) < ins_pct)
            send_cmd(make_insert($urandom,
                                 wide ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 3))));
          else
            send_cmd(make_remove());
        end
        if ($urandom_range(0, 9) == 0) pause_until_drained();
      end
      pause_until_drained();
    end

    idle_pct = 0;
    repeat (4) @(posedge clk);
    $display("ran %0d commands (%0d removes) over four idle/stall patterns", n_sent, n_removes);
    $display("saw %0d overflow and %0d underflow results", overflows, underflows);
    if (err_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue.sv
verif/spq_checker.sv
verif/sorted_priority_queue_tb.sv
